>>> design/qrs_pkg.sv
// qrs_pkg: shared types and constants for the quadratic root solver
// no dependencies; imported by every module of the block but qrs_fifo
`default_nettype none

package qrs_pkg;

   localparam int COEF_BITS     = 16;
   localparam int OUT_BITS      = 48;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH   = 2;

   typedef struct packed {
      logic                        func;
      logic signed [COEF_BITS-1:0] coef_a;
      logic signed [COEF_BITS-1:0] coef_b;
      logic signed [COEF_BITS-1:0] coef_c;
   } qrs_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] root_real;
      logic signed [OUT_BITS-1:0] root_imag;
      logic                       status;
      logic                       last;
   } qrs_rsp_type;

   // class of a queued item
   typedef enum logic [1:0] {
      KIND_ERR  = 2'd0,
      KIND_LIN  = 2'd1,
      KIND_QUAD = 2'd2
   } qrs_kind_type;

endpackage

`default_nettype wire

>>> design/quadratic_root_solver_core.sv
// Quadratic and linear root solver. Each request beat carries a mode and three
// signed 16-bit coefficients; the block returns one response beat (linear mode, or
// a zero leading coefficient flagged in status) or two beats (quadratic mode, last
// on the second) holding real and imaginary parts in signed fixed point with
// FRAC_BITS fraction bits, truncated toward zero and saturated to 48 bits. The front
// end takes a request every cycle while its two-entry queue has room; the back end
// takes one item at a time: an error item goes straight out, a linear item takes one
// NW-bit division and a quadratic item an SW-bit square root and two NW-bit divisions
// (SW = FRAC_BITS+17, NW = FRAC_BITS+18; Q32.16 out by default), one bit per cycle.
// depends on qrs_pkg, qrs_front, qrs_fifo, qrs_back
`default_nettype none

module quadratic_root_solver_core #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire qrs_pkg::qrs_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output qrs_pkg::qrs_rsp_type      rsp_data
);
   import qrs_pkg::*;

   localparam int EW = 2 + 1 + (COEF_BITS + FRAC_BITS + 1) + (2 * COEF_BITS + 1)
                       + (COEF_BITS + 1) + 1;

   logic          q_push, q_full, q_pop, q_empty;
   logic [EW-1:0] q_wdata, q_rdata;

   qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_wdata),
      .q_full    (q_full)
   );

   qrs_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_rdata),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/qrs_fifo.sv
// qrs_fifo: small register queue between the front and back ends
// depends on nothing but its parameters
`default_nettype none

module qrs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [CNTW-1:0]  count_ff;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full) begin
            wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNTW'(push && !full) - CNTW'(pop && !empty);
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue count above depth");

endmodule

`default_nettype wire

>>> design/qrs_front.sv
// qrs_front: accepts coefficient beats, forms products, discriminant and divisor
// depends on qrs_pkg; feeds qrs_fifo
`default_nettype none

module qrs_front #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire qrs_pkg::qrs_req_type req_data,
   output logic                      q_push,
   output logic [2+1+(qrs_pkg::COEF_BITS+FRAC_BITS+1)+(2*qrs_pkg::COEF_BITS+1)
                 +(qrs_pkg::COEF_BITS+1)+1-1:0] q_data,
   input  wire logic                 q_full
);
   import qrs_pkg::*;

   localparam int CB  = COEF_BITS;
   localparam int NBW = CB + FRAC_BITS + 1;
   localparam int DW  = 2 * CB + 1;
   localparam int DVW = CB + 1;

   typedef struct packed {
      qrs_kind_type          kind;
      logic                  neg;
      logic signed [NBW-1:0] nb;
      logic [DW-1:0]         dmag;
      logic [DVW-1:0]        den_mag;
      logic                  den_neg;
   } entry_type;

   function automatic logic [CB-1:0] abs_u(input logic signed [CB-1:0] v);
      abs_u = v[CB-1] ? CB'(-v) : CB'(v);
   endfunction

   logic                 s1_valid_ff;
   logic                 s1_func_ff;
   logic signed [CB-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic [2*CB-1:0]      s1_bb_ff, s1_ac_ff;

   logic [2*CB+1:0] bbx, fac, sum, diff_pos, diff_neg;
   logic            fac_adds, bb_ge;
   logic [CB-1:0]   a_mag;
   entry_type       ent;

   assign req_ready = !s1_valid_ff || !q_full;
   assign q_push    = s1_valid_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // one multiplier each for b*b and a*c, registered
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_func_ff <= req_data.func;
         s1_a_ff    <= req_data.coef_a;
         s1_b_ff    <= req_data.coef_b;
         s1_c_ff    <= req_data.coef_c;
         s1_bb_ff   <= abs_u(req_data.coef_b) * abs_u(req_data.coef_b);
         s1_ac_ff   <= abs_u(req_data.coef_a) * abs_u(req_data.coef_c);
      end
   end

   always_comb begin
      bbx      = {2'b00, s1_bb_ff};
      fac      = {s1_ac_ff, 2'b00};
      sum      = bbx + fac;
      diff_pos = bbx - fac;
      diff_neg = fac - bbx;
      // a and c of opposite sign: -4ac adds to b*b
      fac_adds = (s1_a_ff[CB-1] != s1_c_ff[CB-1]) && (s1_c_ff != '0);
      bb_ge    = (bbx >= fac);
      a_mag    = abs_u(s1_a_ff);

      if (s1_a_ff == '0) begin
         ent.kind = KIND_ERR;
      end else if (s1_func_ff) begin
         ent.kind = KIND_QUAD;
      end else begin
         ent.kind = KIND_LIN;
      end

      if (fac_adds) begin
         ent.neg  = 1'b0;
         ent.dmag = sum[DW-1:0];
      end else if (bb_ge) begin
         ent.neg  = 1'b0;
         ent.dmag = diff_pos[DW-1:0];
      end else begin
         ent.neg  = 1'b1;
         ent.dmag = diff_neg[DW-1:0];
      end

      ent.nb      = -(NBW'(s1_b_ff) <<< FRAC_BITS);
      ent.den_mag = s1_func_ff ? {a_mag, 1'b0} : {1'b0, a_mag};
      ent.den_neg = s1_a_ff[CB-1];
   end

   assign q_data = ent;

endmodule

`default_nettype wire

>>> design/qrs_back.sv
// qrs_back: square root and division sequencer, result register
// depends on qrs_pkg; drains qrs_fifo
`default_nettype none

module qrs_back #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [2+1+(qrs_pkg::COEF_BITS+FRAC_BITS+1)+(2*qrs_pkg::COEF_BITS+1)
                      +(qrs_pkg::COEF_BITS+1)+1-1:0] q_data,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output qrs_pkg::qrs_rsp_type      rsp_data
);
   import qrs_pkg::*;

   localparam int CB   = COEF_BITS;
   localparam int NBW  = CB + FRAC_BITS + 1;
   localparam int DW   = 2 * CB + 1;
   localparam int DVW  = CB + 1;
   localparam int SW   = CB + FRAC_BITS + 1;
   localparam int NW   = CB + FRAC_BITS + 2;
   localparam int NSW  = NW + 1;
   localparam int OW   = OUT_BITS;
   localparam int CW   = (NSW > OW + 1) ? NSW : OW + 1;
   localparam int CNTW = $clog2(NW + 1);

   typedef struct packed {
      qrs_kind_type          kind;
      logic                  neg;
      logic signed [NBW-1:0] nb;
      logic [DW-1:0]         dmag;
      logic [DVW-1:0]        den_mag;
      logic                  den_neg;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SQRT,
      ST_DLOAD,
      ST_DIV,
      ST_EMIT0,
      ST_EMIT1
   } state_type;

   function automatic logic signed [OW-1:0] sat(input logic signed [NSW-1:0] v);
      logic signed [CW-1:0] ext;
      ext = CW'(v);
      if (ext > CW'((64'sd1 <<< (OW - 1)) - 1)) begin
         sat = {1'b0, {(OW-1){1'b1}}};
      end else if (ext < -CW'(64'sd1 <<< (OW - 1))) begin
         sat = {1'b1, {(OW-1){1'b0}}};
      end else begin
         sat = ext[OW-1:0];
      end
   endfunction

   state_type             state_ff;
   entry_type             ent_ff;
   logic                  sel_ff;
   logic [2*SW-1:0]       rad_ff;
   logic [SW:0]           srem_ff;
   logic [SW-1:0]         root_ff;
   logic [NW-1:0]         dnum_ff;
   logic [DVW-1:0]        drem_ff;
   logic                  dneg_ff;
   logic signed [NSW-1:0] q0_ff, q1_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic                  out_valid_ff;
   qrs_rsp_type           out_ff;

   logic [SW+2:0]         s_sh, s_trial, s_rem_in;
   logic                  s_ge;
   logic [DVW:0]          d_sh, d_rem_in;
   logic                  d_ge;
   logic [NW-1:0]         q_mag_in;
   logic signed [NSW-1:0] q_in;
   logic signed [NSW-1:0] nb_ext, s_ext, num0, num1, num_sel;
   logic [NW-1:0]         num_mag;
   logic                  out_free;
   logic                  load_out;
   qrs_rsp_type           beat0, beat1;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign load_out  = ((state_ff == ST_EMIT0) || (state_ff == ST_EMIT1)) && out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      // restoring square root, one result bit per cycle
      s_sh     = {srem_ff, rad_ff[2*SW-1 -: 2]};
      s_trial  = {1'b0, root_ff, 2'b01};
      s_ge     = (s_sh >= s_trial);
      s_rem_in = s_ge ? (s_sh - s_trial) : s_sh;

      // restoring division on magnitudes, one quotient bit per cycle
      d_sh     = {drem_ff, dnum_ff[NW-1]};
      d_ge     = (d_sh >= {1'b0, ent_ff.den_mag});
      d_rem_in = d_ge ? (d_sh - {1'b0, ent_ff.den_mag}) : d_sh;
      q_mag_in = {dnum_ff[NW-2:0], d_ge};
      q_in     = dneg_ff ? -$signed({1'b0, q_mag_in}) : $signed({1'b0, q_mag_in});

      nb_ext = NSW'(ent_ff.nb);
      s_ext  = $signed({2'b00, root_ff});
      if (ent_ff.kind != KIND_QUAD || ent_ff.neg) begin
         num0 = nb_ext;
      end else begin
         num0 = nb_ext + s_ext;
      end
      num1    = ent_ff.neg ? s_ext : nb_ext - s_ext;
      num_sel = sel_ff ? num1 : num0;
      num_mag = num_sel[NSW-1] ? NW'(-num_sel) : NW'(num_sel);

      beat0.root_real = sat(q0_ff);
      beat0.root_imag = ent_ff.neg ? sat(q1_ff) : '0;
      beat0.status    = 1'b0;
      beat0.last      = 1'b0;

      beat1.status = 1'b0;
      beat1.last   = 1'b1;
      unique case (ent_ff.kind)
         KIND_ERR: begin
            beat1.root_real = '0;
            beat1.root_imag = '0;
            beat1.status    = 1'b1;
         end
         KIND_LIN: begin
            beat1.root_real = sat(q0_ff);
            beat1.root_imag = '0;
         end
         KIND_QUAD: begin
            if (ent_ff.neg) begin
               beat1.root_real = sat(q0_ff);
               beat1.root_imag = sat(-q1_ff);
            end else begin
               beat1.root_real = sat(q1_ff);
               beat1.root_imag = '0;
            end
         end
         default: begin
            beat1.root_real = '0;
            beat1.root_imag = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready && !load_out) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  ent_ff   <= q_data;
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               sel_ff <= 1'b0;
               unique case (ent_ff.kind)
                  KIND_ERR:  state_ff <= ST_EMIT1;
                  KIND_LIN:  state_ff <= ST_DLOAD;
                  KIND_QUAD: begin
                     rad_ff   <= (2*SW)'(ent_ff.dmag) << (2 * FRAC_BITS);
                     srem_ff  <= '0;
                     root_ff  <= '0;
                     cnt_ff   <= '0;
                     state_ff <= ST_SQRT;
                  end
                  default:   state_ff <= ST_IDLE;
               endcase
            end
            ST_SQRT: begin
               rad_ff  <= rad_ff << 2;
               srem_ff <= s_rem_in[SW:0];
               root_ff <= {root_ff[SW-2:0], s_ge};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNTW'(SW - 1)) begin
                  state_ff <= ST_DLOAD;
               end
            end
            ST_DLOAD: begin
               dnum_ff  <= num_mag;
               drem_ff  <= '0;
               dneg_ff  <= num_sel[NSW-1] ^ ent_ff.den_neg;
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               dnum_ff <= q_mag_in;
               drem_ff <= d_rem_in[DVW-1:0];
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNTW'(NW - 1)) begin
                  if (sel_ff) begin
                     q1_ff    <= q_in;
                     state_ff <= ST_EMIT0;
                  end else begin
                     q0_ff <= q_in;
                     if (ent_ff.kind == KIND_QUAD) begin
                        sel_ff   <= 1'b1;
                        state_ff <= ST_DLOAD;
                     end else begin
                        state_ff <= ST_EMIT1;
                     end
                  end
               end
            end
            ST_EMIT0: begin
               if (out_free) begin
                  out_ff       <= beat0;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_EMIT1;
               end
            end
            ST_EMIT1: begin
               if (out_free) begin
                  out_ff       <= beat1;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status) |->
         (out_ff.last && out_ff.root_real == '0 && out_ff.root_imag == '0))
      else $error("error beat not zeroed or not last");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < CNTW'(NW)))
      else $error("divider step count out of range");

   a_pair_conj: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ready && !out_ff.last && out_ff.root_imag != '0) |=>
         (out_valid_ff && out_ff.last && out_ff.root_real == $past(out_ff.root_real)
          && out_ff.root_imag == -$past(out_ff.root_imag)))
      else $error("complex pair not conjugate");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking testbench for quadratic_root_solver_core
// depends on qrs_pkg and the solver RTL; predicts each root beat and compares it in order
`timescale 1ns / 100ps

module tb_top;
   import qrs_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int DRAIN_CYCLES = 150;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   qrs_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   qrs_rsp_type rsp_data;

   qrs_rsp_type root_q[$];
   int          err_cnt = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_req = 0;
   int          hold_cnt = 0;

   quadratic_root_solver_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("tb_top: errors");
      $finish;
   end

   function automatic logic signed [OUT_BITS-1:0] sat_part(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OUT_BITS-1:0];
   endfunction

   // floor(sqrt(n)) for n below 2^128
   function automatic longint int_sqrt(logic [127:0] n);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         t = r | (128'd1 << k);
         if (t * t <= n) r = t;
      end
      return longint'(r[63:0]);
   endfunction

   function automatic int solve_roots(qrs_req_type q, output qrs_rsp_type r0,
                                      output qrs_rsp_type r1);
      longint a, b, c, nb, den, disc, s, re, im;
      logic [127:0] scaled;
      r0 = '0;
      r1 = '0;
      a = q.coef_a;
      b = q.coef_b;
      c = q.coef_c;
      nb = -b * (longint'(1) <<< FRAC);
      if (a == 0) begin
         r0.status = 1'b1;
         r0.last = 1'b1;
         return 1;
      end
      if (!q.func) begin
         r0.root_real = sat_part(nb / a);
         r0.last = 1'b1;
         return 1;
      end
      disc = b * b - 4 * a * c;
      scaled = 128'((disc < 0) ? -disc : disc) << (2 * FRAC);
      s = int_sqrt(scaled);
      den = 2 * a;
      if (disc >= 0) begin
         r0.root_real = sat_part((nb + s) / den);
         r1.root_real = sat_part((nb - s) / den);
      end else begin
         re = nb / den;
         im = s / den;
         r0.root_real = sat_part(re);
         r0.root_imag = sat_part(im);
         r1.root_real = sat_part(re);
         r1.root_imag = sat_part(-im);
      end
      r1.last = 1'b1;
      return 2;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   // receiver side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt <= 0;
      end else if (hold_req > 0 && hold_cnt == 0) begin
         hold_cnt <= hold_req;
         hold_req = 0;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      qrs_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (root_q.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            want = root_q.pop_front();
            if (rsp_data.root_real !== want.root_real)
               report_mismatch("root_real", rsp_data.root_real, want.root_real);
            if (rsp_data.root_imag !== want.root_imag)
               report_mismatch("root_imag", rsp_data.root_imag, want.root_imag);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   task automatic send_coefs(logic func, logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c);
      qrs_req_type q;
      qrs_rsp_type r0, r1;
      int n;
      q.func = func;
      q.coef_a = a;
      q.coef_b = b;
      q.coef_c = c;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      n = solve_roots(q, r0, r1);
      root_q.push_back(r0);
      if (n == 2) root_q.push_back(r1);
   endtask

   task automatic wait_roots_done();
      req_valid <= 1'b0;
      while (root_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'($urandom_range(20)) - 16'sd10;
         3: return 16'($urandom_range(255)) - 16'sd128;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(int n);
      logic signed [15:0] a;
      repeat (n) begin
         a = ($urandom_range(19) == 0) ? 16'sd0 : pick_coef();
         send_coefs($urandom_range(3) != 0, a, pick_coef(), pick_coef());
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_coefs(1'b0, 16'sd2, 16'sd4, 16'sd0);              // linear
      send_coefs(1'b0, -16'sd3, 16'sd7, 16'sd9);
      send_coefs(1'b0, 16'sd1, -16'sd32768, 16'sd0);
      send_coefs(1'b0, -16'sd1, -16'sd32768, 16'sd0);
      send_coefs(1'b0, 16'sd32767, 16'sd1, 16'sd0);
      send_coefs(1'b0, 16'sd0, 16'sd5, 16'sd5);              // zero leading coef
      send_coefs(1'b1, 16'sd0, 16'sd5, 16'sd5);
      send_coefs(1'b1, 16'sd1, -16'sd3, 16'sd2);             // two real roots
      send_coefs(1'b1, 16'sd1, 16'sd2, 16'sd1);              // double root
      send_coefs(1'b1, 16'sd1, 16'sd0, 16'sd1);              // complex pair
      send_coefs(1'b1, -16'sd2, 16'sd3, 16'sd5);
      send_coefs(1'b1, 16'sd1, -16'sd32768, -16'sd32768);    // huge discriminant
      send_coefs(1'b1, -16'sd32768, -16'sd32768, 16'sd32767);
      send_coefs(1'b1, 16'sd32767, 16'sd0, 16'sd32767);
      send_coefs(1'b1, -16'sd32768, 16'sd32767, -16'sd32768);
      send_coefs(1'b1, 16'sd1, 16'sd1, 16'sd0);
      send_coefs(1'b1, 16'sd3, 16'sd0, 16'sd0);
      send_coefs(1'b1, -16'sd1, 16'sd0, -16'sd32768);
      send_coefs(1'b1, 16'sd1, 16'sd32767, 16'sd32767);
      send_coefs(1'b0, -16'sd32768, 16'sd32767, -16'sd1);
      wait_roots_done();
   endtask

   task automatic test_random_phases();
      send_idle_pct = 0;  rsp_stall_pct = 0;  send_random(100);
      send_idle_pct = 83; rsp_stall_pct = 0;  send_random(100);
      send_idle_pct = 0;  rsp_stall_pct = 83; send_random(100);
      send_idle_pct = 28; rsp_stall_pct = 28; send_random(100);
      wait_roots_done();
   endtask

   // receiver holds off long enough for the queue to fill and back up the input
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 10;
      hold_req = 600;
      send_random(15);
      wait_roots_done();
   endtask

   task automatic test_pause();
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      send_random(10);
      wait_roots_done();
      send_random(10);
      wait_roots_done();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_phases();
      test_pause();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0 && root_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

>>> quadratic_root_solver_core.f
design/qrs_pkg.sv
design/qrs_fifo.sv
design/qrs_front.sv
design/qrs_back.sv
design/quadratic_root_solver_core.sv
dv/tb_top.sv
